[src/tsr_pkg.sv]
// tsr_pkg: shared types and constants of the tcp segment reassembly block
// no dependencies

package tsr_pkg;

    localparam int unsigned SEQ_W          = 32;
    localparam int unsigned LEN_W          = 16;
    localparam int unsigned TAG_W          = 8;
    localparam int unsigned TSR_TABLE_DEPTH = 16;
    localparam int unsigned TSR_FIFO_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_SEGMENT = 2'd0,
        OP_SET_ISN = 2'd1,
        OP_RESET   = 2'd2,
        OP_FIN     = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        EV_INORDER   = 4'd0,
        EV_BUFFERED  = 4'd1,
        EV_STORED    = 4'd2,
        EV_DISCARD   = 4'd3,
        EV_NOT_INIT  = 4'd4,
        EV_AFTER_FIN = 4'd5,
        EV_FIN       = 4'd6,
        EV_FULL      = 4'd7,
        EV_NONE      = 4'd8
    } t_event;

    typedef struct packed {
        t_opcode            opcode;
        logic [SEQ_W-1:0]   seq_number;
        logic [LEN_W-1:0]   seg_length;
        logic               fin_bit;
        logic [TAG_W-1:0]   payload_tag;
    } t_seg_in;

    typedef struct packed {
        t_event             event_kind;
        logic [SEQ_W-1:0]   start_seq;
        logic [LEN_W-1:0]   range_length;
        logic [LEN_W-1:0]   skip_bytes;
        logic [TAG_W-1:0]   tag_out;
        logic [SEQ_W-1:0]   next_seq;
        logic               last;
    } t_res;

    typedef struct packed {
        t_opcode            op;
        logic [SEQ_W-1:0]   seq;
        logic [LEN_W-1:0]   len;
        logic               len_nz;
        logic               fin;
        logic [TAG_W-1:0]   tag;
        logic [SEQ_W-1:0]   seq_end;
    } t_cmd;

    typedef struct packed {
        logic [SEQ_W-1:0]   start;
        logic [LEN_W-1:0]   len;
        logic [TAG_W-1:0]   tag;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLASS,
        S_DECIDE,
        S_ST_RD,
        S_ST_CHK,
        S_ST_WR,
        S_FIN,
        S_DRN_RD,
        S_DRN_CHK,
        S_INC,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        RET_FIN,
        RET_INC,
        RET_DONE
    } t_ret;

endpackage

[src/tcp_segment_reassembly.sv]
// tcp_segment_reassembly: descriptor-level tcp reassembly, top level
// transactions are handled one at a time; a store walks the table at most once,
// and each delivery from the table restarts a walk
// reset: synchronous, clears queues, sequence state and table valid bits, no table sweep
// depends on tsr_pkg, tsr_front, tsr_back, tsr_fifo

module tcp_segment_reassembly #(
    parameter int unsigned TABLE_DEPTH = tsr_pkg::TSR_TABLE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    input  tsr_pkg::t_seg_in  i_seg,
    output logic              full,
    output logic              empty,
    input  logic              pop,
    output tsr_pkg::t_res     o_res
);

    import tsr_pkg::*;

    t_cmd w_cmd;
    logic w_cmd_empty, w_cmd_pop;
    logic w_res_full, w_res_push;
    t_res w_res;

    tsr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_seg   (i_seg),
        .o_full  (full),
        .i_pop   (w_cmd_pop),
        .o_cmd   (w_cmd),
        .o_empty (w_cmd_empty)
    );

    tsr_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_vld  (!w_cmd_empty),
        .i_cmd      (w_cmd),
        .o_cmd_pop  (w_cmd_pop),
        .i_res_full (w_res_full),
        .o_res_push (w_res_push),
        .o_res      (w_res)
    );

    tsr_fifo #(
        .t_data (t_res),
        .DEPTH  (TSR_FIFO_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (o_res),
        .o_empty (empty)
    );

endmodule

[src/tsr_fifo.sv]
// tsr_fifo: small first-in first-out queue of any packed type
// uses tsr_pkg for the default depth

module tsr_fifo #(
    parameter type         t_data = logic,
    parameter int unsigned DEPTH  = tsr_pkg::TSR_FIFO_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_data i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_data o_data,
    output logic  o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_data          r_mem [DEPTH];
    logic [AW-1:0]  r_wr, r_rd, n_wr, n_rd;
    logic [AW:0]    r_cnt, n_cnt;
    logic           w_wr, w_rd;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_wr) begin
            n_wr = (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
        end
        if (w_rd) begin
            n_rd = (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[src/tsr_front.sv]
// tsr_front: accepts input transactions, decodes them into commands
// depends on tsr_pkg and tsr_fifo

module tsr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tsr_pkg::t_seg_in  i_seg,
    output logic              o_full,
    input  logic              i_pop,
    output tsr_pkg::t_cmd     o_cmd,
    output logic              o_empty
);

    import tsr_pkg::*;

    t_cmd w_cmd;

    always_comb begin
        w_cmd.op      = i_seg.opcode;
        w_cmd.seq     = i_seg.seq_number;
        w_cmd.len     = i_seg.seg_length;
        w_cmd.len_nz  = (i_seg.seg_length != '0);
        w_cmd.fin     = i_seg.fin_bit;
        w_cmd.tag     = i_seg.payload_tag;
        w_cmd.seq_end = i_seg.seq_number + SEQ_W'(i_seg.seg_length);
    end

    tsr_fifo #(
        .t_data (t_cmd),
        .DEPTH  (TSR_FIFO_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (o_cmd),
        .o_empty (o_empty)
    );

endmodule

[src/tsr_back.sv]
// tsr_back: sequence tracking, out-of-order table and result generation
// depends on tsr_pkg

module tsr_back #(
    parameter int unsigned TABLE_DEPTH = tsr_pkg::TSR_TABLE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_vld,
    input  tsr_pkg::t_cmd  i_cmd,
    output logic           o_cmd_pop,
    input  logic           i_res_full,
    output logic           o_res_push,
    output tsr_pkg::t_res  o_res
);

    import tsr_pkg::*;

    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    function automatic t_res mk_res(t_event k, logic [SEQ_W-1:0] s, logic [LEN_W-1:0] l,
                                    logic [LEN_W-1:0] sk, logic [TAG_W-1:0] t,
                                    logic [SEQ_W-1:0] e);
        t_res r;
        r.event_kind   = k;
        r.start_seq    = s;
        r.range_length = l;
        r.skip_bytes   = sk;
        r.tag_out      = t;
        r.next_seq     = e;
        r.last         = 1'b0;
        return r;
    endfunction

    t_state                 r_state, n_state;
    t_cmd                   r_cmd, n_cmd;
    logic [SEQ_W-1:0]       r_dend, n_dend, r_dov, n_dov, r_dsn, n_dsn;
    logic [SEQ_W-1:0]       r_nexp, n_nexp;
    logic                   r_init, n_init, r_fin, n_fin;
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    logic [IW-1:0]          r_idx, n_idx, r_free, n_free, r_slot, n_slot;
    logic                   r_free_vld, n_free_vld;
    logic [SEQ_W-1:0]       r_sq, n_sq;
    logic [LEN_W-1:0]       r_ln, n_ln;
    t_res                   r_pend, n_pend;
    logic                   r_pend_vld, n_pend_vld;
    t_ret                   r_ret, n_ret;
    t_entry                 r_mem [TABLE_DEPTH];
    t_entry                 r_rd;

    logic                   w_emit, w_we, w_can_emit, w_idx_last;
    t_res                   w_new;
    logic                   w_after_end, w_trim, w_fwd, w_ov_ge;
    logic [LEN_W-1:0]       w_ln;
    logic [SEQ_W-1:0]       w_sq;
    logic [LEN_W-1:0]       w_sk;
    logic                   w_d_disc, w_d_late, w_d_deliver, w_d_store;
    logic                   w_hit_st, w_hit_dr, w_fin_ok;
    t_state                 w_ret_state;

    assign w_can_emit  = !r_pend_vld || !i_res_full;
    assign w_idx_last  = (r_idx == IW'(TABLE_DEPTH-1));
    assign w_after_end = (r_dend != '0) && !r_dend[SEQ_W-1];
    assign w_trim      = r_cmd.len_nz && (r_dov != '0) && !r_dov[SEQ_W-1];
    assign w_fwd       = (r_dsn != '0) && !r_dsn[SEQ_W-1];
    assign w_ov_ge     = (r_dov[SEQ_W-1:LEN_W] != '0) || (r_dov[LEN_W-1:0] >= r_cmd.len);
    assign w_ln        = w_trim ? r_cmd.len - r_dov[LEN_W-1:0] : r_cmd.len;
    assign w_sq        = w_trim ? r_nexp : r_cmd.seq;
    assign w_sk        = w_trim ? r_dov[LEN_W-1:0] : '0;
    assign w_d_disc    = r_cmd.len_nz && (!w_after_end || (w_trim && w_ov_ge));
    assign w_d_late    = r_fin && (w_ln != '0);
    assign w_d_deliver = (w_ln != '0) && (w_trim || (r_dsn == '0));
    assign w_d_store   = (w_ln != '0) && w_fwd;
    assign w_hit_st    = (r_rd.start == r_sq);
    assign w_hit_dr    = (r_rd.start == r_nexp);
    assign w_fin_ok    = r_cmd.fin && (r_cmd.seq_end == r_nexp) && !r_fin;

    always_comb begin
        unique case (r_ret)
            RET_FIN: w_ret_state = S_FIN;
            RET_INC: w_ret_state = S_INC;
            default: w_ret_state = S_DONE;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_vld) n_state = S_CLASS;
            end
            S_CLASS: n_state = S_DECIDE;
            S_DECIDE: begin
                unique case (r_cmd.op)
                    OP_SEGMENT: begin
                        priority if (!r_init)    n_state = S_DONE;
                        else if (w_d_disc)       n_state = S_DONE;
                        else if (w_d_late)       n_state = S_DONE;
                        else if (w_d_deliver)    n_state = S_DRN_RD;
                        else if (w_d_store)      n_state = S_ST_RD;
                        else                     n_state = S_FIN;
                    end
                    OP_SET_ISN: n_state = r_init ? S_DONE : S_DRN_RD;
                    OP_RESET:   n_state = S_DONE;
                    default:    n_state = (!r_fin && r_init) ? S_DRN_RD : S_DONE;
                endcase
            end
            S_ST_RD: begin
                priority if (r_valid[r_idx]) n_state = S_ST_CHK;
                else if (w_idx_last)         n_state = S_ST_WR;
                else                         n_state = r_state;
            end
            S_ST_CHK: begin
                priority if (w_hit_st)       n_state = S_ST_WR;
                else if (!w_idx_last)        n_state = S_ST_RD;
                else if (r_free_vld)         n_state = S_ST_WR;
                else                         n_state = S_FIN;
            end
            S_ST_WR: n_state = S_FIN;
            S_FIN: begin
                priority if (!w_fin_ok)      n_state = S_DONE;
                else if (w_can_emit)         n_state = S_DRN_RD;
                else                         n_state = r_state;
            end
            S_DRN_RD: begin
                priority if (r_valid[r_idx]) n_state = S_DRN_CHK;
                else if (w_idx_last)         n_state = w_ret_state;
                else                         n_state = r_state;
            end
            S_DRN_CHK: begin
                priority if (w_hit_dr) begin
                    if (w_can_emit) n_state = S_DRN_RD;
                end else if (w_idx_last) begin
                    n_state = w_ret_state;
                end else begin
                    n_state = S_DRN_RD;
                end
            end
            S_INC: n_state = S_DONE;
            S_DONE: begin
                if (!i_res_full) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_cmd      = r_cmd;
        n_dend     = r_dend;
        n_dov      = r_dov;
        n_dsn      = r_dsn;
        n_nexp     = r_nexp;
        n_init     = r_init;
        n_fin      = r_fin;
        n_valid    = r_valid;
        n_idx      = r_idx;
        n_free     = r_free;
        n_free_vld = r_free_vld;
        n_slot     = r_slot;
        n_sq       = r_sq;
        n_ln       = r_ln;
        n_ret      = r_ret;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = r_pend;
        w_emit     = 1'b0;
        w_new      = r_pend;
        w_we       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd_pop = i_cmd_vld;
                n_cmd     = i_cmd;
            end
            S_CLASS: begin
                n_dend = r_cmd.seq_end - r_nexp;
                n_dov  = r_nexp - r_cmd.seq;
                n_dsn  = r_cmd.seq - r_nexp;
            end
            S_DECIDE: begin
                n_idx      = '0;
                n_free_vld = 1'b0;
                unique case (r_cmd.op)
                    OP_SEGMENT: begin
                        priority if (!r_init) begin
                            w_emit = 1'b1;
                            w_new  = mk_res(EV_NOT_INIT, r_cmd.seq, r_cmd.len, '0,
                                            r_cmd.tag, r_nexp);
                        end else if (w_d_disc) begin
                            w_emit = 1'b1;
                            w_new  = mk_res(EV_DISCARD, r_cmd.seq, r_cmd.len, '0,
                                            r_cmd.tag, r_nexp);
                        end else if (w_d_late) begin
                            w_emit = 1'b1;
                            w_new  = mk_res(EV_AFTER_FIN, w_sq, w_ln, w_sk, r_cmd.tag, r_nexp);
                        end else if (w_d_deliver) begin
                            w_emit = 1'b1;
                            n_nexp = r_nexp + SEQ_W'(w_ln);
                            n_ret  = RET_FIN;
                            w_new  = mk_res(EV_INORDER, w_sq, w_ln, w_sk, r_cmd.tag,
                                            r_nexp + SEQ_W'(w_ln));
                        end else begin
                            n_sq = w_sq;
                            n_ln = w_ln;
                        end
                    end
                    OP_SET_ISN: begin
                        if (!r_init) begin
                            n_nexp = r_cmd.seq;
                            n_init = 1'b1;
                            n_ret  = RET_DONE;
                            w_emit = 1'b1;
                            w_new  = mk_res(EV_NONE, '0, '0, '0, '0, r_cmd.seq);
                        end
                    end
                    OP_RESET: begin
                        n_nexp  = '0;
                        n_init  = 1'b0;
                        n_fin   = 1'b0;
                        n_valid = '0;
                    end
                    default: begin
                        if (!r_fin) begin
                            n_fin  = 1'b1;
                            n_ret  = RET_DONE;
                            w_emit = 1'b1;
                            w_new  = mk_res(EV_FIN, r_nexp, '0, '0, '0, r_nexp);
                        end
                    end
                endcase
            end
            S_ST_RD: begin
                if (!r_valid[r_idx]) begin
                    if (!r_free_vld) begin
                        n_free     = r_idx;
                        n_free_vld = 1'b1;
                    end
                    if (w_idx_last) begin
                        n_slot = r_free_vld ? r_free : r_idx;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_ST_CHK: begin
                priority if (w_hit_st) begin
                    n_slot = r_idx;
                end else if (!w_idx_last) begin
                    n_idx = r_idx + 1'b1;
                end else if (r_free_vld) begin
                    n_slot = r_free;
                end else begin
                    w_emit = 1'b1;
                    w_new  = mk_res(EV_FULL, r_cmd.seq, r_cmd.len, '0, r_cmd.tag, r_nexp);
                end
            end
            S_ST_WR: begin
                w_we            = 1'b1;
                n_valid[r_slot] = 1'b1;
                w_emit          = 1'b1;
                w_new           = mk_res(EV_STORED, r_sq, r_ln, '0, r_cmd.tag, r_nexp);
            end
            S_FIN: begin
                if (w_fin_ok && w_can_emit) begin
                    n_fin  = 1'b1;
                    n_ret  = RET_INC;
                    n_idx  = '0;
                    w_emit = 1'b1;
                    w_new  = mk_res(EV_FIN, r_cmd.seq_end, '0, '0, '0, r_nexp);
                end
            end
            S_DRN_RD: begin
                if (!r_valid[r_idx] && !w_idx_last) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DRN_CHK: begin
                priority if (w_hit_dr) begin
                    if (w_can_emit) begin
                        n_valid[r_idx] = 1'b0;
                        n_nexp         = r_nexp + SEQ_W'(r_rd.len);
                        n_idx          = '0;
                        w_emit         = 1'b1;
                        w_new          = mk_res(EV_BUFFERED, r_rd.start, r_rd.len, '0,
                                                r_rd.tag, r_nexp + SEQ_W'(r_rd.len));
                    end
                end else if (!w_idx_last) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_idx = r_idx;
                end
            end
            S_INC: begin
                n_nexp          = r_nexp + 1'b1;
                n_pend.next_seq = r_nexp + 1'b1;
            end
            S_DONE: begin
                if (r_pend_vld) begin
                    o_res = r_pend;
                end else begin
                    o_res = mk_res(EV_NONE, '0, '0, '0, '0, r_nexp);
                end
                o_res.last = 1'b1;
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_pend_vld = 1'b0;
                end
            end
            default: begin
                n_pend_vld = 1'b0;
            end
        endcase
        if (w_emit) begin
            if (r_pend_vld) begin
                o_res_push = 1'b1;
                o_res      = r_pend;
                o_res.last = 1'b0;
            end
            n_pend     = w_new;
            n_pend_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_nexp     <= '0;
            r_init     <= 1'b0;
            r_fin      <= 1'b0;
            r_valid    <= '0;
            r_pend_vld <= 1'b0;
            r_free_vld <= 1'b0;
            r_ret      <= RET_DONE;
        end else begin
            r_state    <= n_state;
            r_nexp     <= n_nexp;
            r_init     <= n_init;
            r_fin      <= n_fin;
            r_valid    <= n_valid;
            r_pend_vld <= n_pend_vld;
            r_free_vld <= n_free_vld;
            r_ret      <= n_ret;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_dend <= n_dend;
        r_dov  <= n_dov;
        r_dsn  <= n_dsn;
        r_idx  <= n_idx;
        r_free <= n_free;
        r_slot <= n_slot;
        r_sq   <= n_sq;
        r_ln   <= n_ln;
        r_pend <= n_pend;
    end

    // out-of-order table
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_slot] <= '{start: r_sq, len: r_ln, tag: r_cmd.tag};
        end
        r_rd <= r_mem[r_idx];
    end

endmodule

[sim/tcp_segment_reassembly_tb.sv]
// tcp_segment_reassembly_tb: self-checking testbench of the tcp segment reassembly block
// a predictor of the sequence state and the out-of-order table checks every result transaction
// depends on tsr_pkg and tcp_segment_reassembly
`timescale 1ns / 100ps

module tcp_segment_reassembly_tb;
    import tsr_pkg::*;

    localparam int unsigned DEPTH     = TSR_TABLE_DEPTH;
    localparam int unsigned MAX_RES   = DEPTH + 2;
    localparam int unsigned N_ITEMS   = 455;
    localparam int unsigned CALM_LEFT = 40;
    localparam longint      LIMIT     = 2000000;

    logic    i_clk;
    logic    i_rst_n;
    logic    push;
    t_seg_in i_seg;
    logic    full;
    logic    empty;
    logic    pop;
    t_res    o_res;

    tcp_segment_reassembly dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .i_seg   (i_seg),
        .full    (full),
        .empty   (empty),
        .pop     (pop),
        .o_res   (o_res)
    );

    // stimulus and expectations
    t_seg_in seg_q[$];
    bit      hold_q[$];
    t_res    want_q[$];
    t_res    step_q[$];

    // predicted block state
    logic [SEQ_W-1:0] rcv_next;
    bit               rcv_init;
    bit               rcv_fin;
    bit               tbl_valid [DEPTH];
    logic [SEQ_W-1:0] tbl_start [DEPTH];
    logic [LEN_W-1:0] tbl_len   [DEPTH];
    logic [TAG_W-1:0] tbl_tag   [DEPTH];

    int     errors;
    int     n_sent;
    int     n_checked;
    int     n_delivered;
    int     n_full;
    int     drv_gap;
    int     rx_gap;
    bit     calm;
    longint cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit seq_later(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d != 0 && d < 32'h8000_0000;
    endfunction

    task automatic note(t_event k, logic [31:0] st, logic [31:0] ln, logic [31:0] sk,
                        logic [31:0] tg);
        t_res r;
        if (step_q.size() >= MAX_RES) return;
        r.event_kind   = k;
        r.start_seq    = st;
        r.range_length = ln[LEN_W-1:0];
        r.skip_bytes   = sk[LEN_W-1:0];
        r.tag_out      = tg[TAG_W-1:0];
        r.next_seq     = rcv_next;
        r.last         = 1'b0;
        step_q.push_back(r);
    endtask

    task automatic clear_state();
        rcv_next = '0;
        rcv_init = 1'b0;
        rcv_fin  = 1'b0;
        for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
    endtask

    task automatic drain_ready();
        bit found;
        found = 1'b1;
        if (!rcv_init) return;
        while (found) begin
            found = 1'b0;
            for (int i = 0; i < DEPTH; i++) begin
                if (tbl_valid[i] && tbl_start[i] == rcv_next) begin
                    tbl_valid[i] = 1'b0;
                    rcv_next     = rcv_next + tbl_len[i];
                    note(EV_BUFFERED, tbl_start[i], tbl_len[i], 0, tbl_tag[i]);
                    n_delivered++;
                    found = 1'b1;
                    break;
                end
            end
        end
    endtask

    task automatic hold_future(logic [31:0] st, logic [31:0] ln, logic [7:0] tg,
                               logic [31:0] seq_in, logic [31:0] len_in);
        int slot;
        slot = -1;
        for (int i = 0; i < DEPTH; i++)
            if (slot < 0 && tbl_valid[i] && tbl_start[i] == st) slot = i;
        for (int i = 0; i < DEPTH; i++)
            if (slot < 0 && !tbl_valid[i]) slot = i;
        if (slot < 0) begin
            note(EV_FULL, seq_in, len_in, 0, tg);
            n_full++;
            return;
        end
        tbl_valid[slot] = 1'b1;
        tbl_start[slot] = st;
        tbl_len[slot]   = ln[LEN_W-1:0];
        tbl_tag[slot]   = tg;
        note(EV_STORED, st, ln, 0, tg);
    endtask

    task automatic take_segment(t_seg_in s);
        logic [31:0] st, ln, sk, ov, fin_end, len_in;
        len_in  = s.seg_length;
        st      = s.seq_number;
        ln      = len_in;
        sk      = 0;
        fin_end = s.seq_number + len_in;
        if (!rcv_init) begin
            note(EV_NOT_INIT, s.seq_number, len_in, 0, s.payload_tag);
            return;
        end
        if (len_in != 0 && !seq_later(fin_end, rcv_next)) begin
            note(EV_DISCARD, s.seq_number, len_in, 0, s.payload_tag);
            return;
        end
        if (len_in != 0 && seq_later(rcv_next, s.seq_number)) begin
            ov = rcv_next - s.seq_number;
            if (ov >= len_in) begin
                note(EV_DISCARD, s.seq_number, len_in, 0, s.payload_tag);
                return;
            end
            st = rcv_next;
            ln = len_in - ov;
            sk = ov;
        end
        if (rcv_fin && ln != 0) begin
            note(EV_AFTER_FIN, st, ln, sk, s.payload_tag);
            ln = 0;
        end
        if (ln != 0 && st == rcv_next) begin
            rcv_next = rcv_next + ln;
            note(EV_INORDER, st, ln, sk, s.payload_tag);
            n_delivered++;
            drain_ready();
        end else if (ln != 0 && seq_later(st, rcv_next)) begin
            hold_future(st, ln, s.payload_tag, s.seq_number, len_in);
        end
        if (s.fin_bit && fin_end == rcv_next && !rcv_fin) begin
            rcv_fin = 1'b1;
            note(EV_FIN, fin_end, 0, 0, 0);
            drain_ready();
            rcv_next = rcv_next + 1;
            step_q[step_q.size()-1].next_seq = rcv_next;
        end
    endtask

    task automatic predict_transaction(t_seg_in s);
        step_q.delete();
        case (s.opcode)
            OP_SEGMENT: take_segment(s);
            OP_SET_ISN: begin
                if (!rcv_init) begin
                    rcv_next = s.seq_number;
                    rcv_init = 1'b1;
                    note(EV_NONE, 0, 0, 0, 0);
                    drain_ready();
                end else begin
                    note(EV_NONE, 0, 0, 0, 0);
                end
            end
            OP_RESET: begin
                clear_state();
                note(EV_NONE, 0, 0, 0, 0);
            end
            default: begin
                if (!rcv_fin) begin
                    rcv_fin = 1'b1;
                    note(EV_FIN, rcv_next, 0, 0, 0);
                    drain_ready();
                end else begin
                    note(EV_NONE, 0, 0, 0, 0);
                end
            end
        endcase
        if (step_q.size() == 0) note(EV_NONE, 0, 0, 0, 0);
        step_q[step_q.size()-1].last = 1'b1;
        foreach (step_q[i]) want_q.push_back(step_q[i]);
    endtask

    task automatic add(t_opcode op, logic [31:0] sq, logic [15:0] ln, bit fin, logic [7:0] tg,
                       bit hold = 1'b0);
        t_seg_in s;
        s.opcode      = op;
        s.seq_number  = sq;
        s.seg_length  = ln;
        s.fin_bit     = fin;
        s.payload_tag = tg;
        seg_q.push_back(s);
        hold_q.push_back(hold);
    endtask

    task automatic add_episode();
        logic [31:0] isn, pos;
        logic [31:0] st [24];
        logic [15:0] ln [24];
        logic [31:0] ts;
        logic [15:0] tl;
        int n, j;
        bit hold_first;
        add(OP_RESET, $urandom, $urandom, $urandom_range(0, 1), $urandom,
            $urandom_range(0, 9) == 0);
        if ($urandom_range(0, 3) == 0)
            add(OP_SEGMENT, $urandom, $urandom_range(0, 100), $urandom_range(0, 1), $urandom);
        isn = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 300) : $urandom;
        add(OP_SET_ISN, isn, $urandom, $urandom_range(0, 1), $urandom);
        hold_first = $urandom_range(0, 5) == 0;
        n = hold_first ? $urandom_range(15, 20) : $urandom_range(3, 12);
        pos = isn;
        for (int k = 0; k < n; k++) begin
            ln[k] = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(1, 65535))
                                                 : 16'($urandom_range(1, 80));
            st[k] = pos;
            pos   = pos + ln[k];
        end
        if (!hold_first) begin
            for (int k = 0; k + 1 < n; k++) begin
                if ($urandom_range(0, 2) == 0) begin
                    ts = st[k]; st[k] = st[k+1]; st[k+1] = ts;
                    tl = ln[k]; ln[k] = ln[k+1]; ln[k+1] = tl;
                end
            end
        end
        for (int k = 0; k < n; k++) begin
            j = hold_first ? (k + 1) % n : k;
            add(OP_SEGMENT, st[j], ln[j], $urandom_range(0, 19) == 0, $urandom);
            if ($urandom_range(0, 7) == 0)
                add(OP_SEGMENT, st[j] - $urandom_range(0, 20), ln[j] + $urandom_range(0, 30),
                    1'b0, $urandom);
            if ($urandom_range(0, 11) == 0)
                add(t_opcode'($urandom_range(0, 3)), $urandom, $urandom,
                    $urandom_range(0, 1), $urandom);
        end
        case ($urandom_range(0, 3))
            0: add(OP_SEGMENT, pos, 16'd0, 1'b1, $urandom);
            1: add(OP_FIN, $urandom, $urandom, $urandom_range(0, 1), $urandom);
            2: add(OP_SEGMENT, pos, 16'($urandom_range(1, 40)), 1'b1, $urandom);
            default: ;
        endcase
        if ($urandom_range(0, 2) == 0)
            add(OP_SEGMENT, pos + 1, 16'($urandom_range(1, 40)), 1'b0, $urandom);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push    <= 1'b0;
            drv_gap <= 0;
        end else begin
            if (push && !full) begin
                predict_transaction(i_seg);
                n_sent++;
            end
            if (!push || !full) begin
                if (drv_gap > 0 && !calm) begin
                    drv_gap <= drv_gap - 1;
                    push    <= 1'b0;
                end else if (seg_q.size() > 0 && !(hold_q[0] && want_q.size() > 0)) begin
                    push  <= 1'b1;
                    i_seg <= seg_q.pop_front();
                    void'(hold_q.pop_front());
                    drv_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res w;
        if (!i_rst_n) begin
            pop    <= 1'b0;
            rx_gap <= 0;
        end else begin
            if (pop && !empty) begin
                if (want_q.size() == 0) begin
                    $error("result transaction with no expectation: kind %0d", o_res.event_kind);
                    errors++;
                end else begin
                    w = want_q.pop_front();
                    check_field("event_kind", w.event_kind, o_res.event_kind);
                    check_field("start_seq", w.start_seq, o_res.start_seq);
                    check_field("range_length", w.range_length, o_res.range_length);
                    check_field("skip_bytes", w.skip_bytes, o_res.skip_bytes);
                    check_field("tag_out", w.tag_out, o_res.tag_out);
                    check_field("next_seq", w.next_seq, o_res.next_seq);
                    check_field("last", w.last, o_res.last);
                    n_checked++;
                end
            end
            if (calm) begin
                pop <= 1'b1;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                pop    <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                rx_gap <= $urandom_range(0, 2);
                pop    <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) calm <= seg_q.size() < CALM_LEFT;

    initial begin
        errors = 0; n_sent = 0; n_checked = 0; n_delivered = 0; n_full = 0;
        cycles = 0;
        calm    = 1'b0;
        i_rst_n = 1'b0;
        push    = 1'b0;
        pop     = 1'b0;
        i_seg   = '0;
        clear_state();

        // directed part
        add(OP_SEGMENT, 32'd100, 16'd10, 1'b0, 8'h00);
        add(OP_SET_ISN, 32'hFFFF_FFF0, 16'd0, 1'b0, 8'h00);
        add(OP_SET_ISN, 32'h1234_5678, 16'hFFFF, 1'b1, 8'hFF);
        add(OP_SEGMENT, 32'hFFFF_FFF0, 16'd0, 1'b0, 8'h11);
        add(OP_SEGMENT, 32'hFFFF_FFF0, 16'd8, 1'b0, 8'h12);
        add(OP_SEGMENT, 32'h0000_0008, 16'd4, 1'b0, 8'h13);
        add(OP_SEGMENT, 32'h0000_0008, 16'd6, 1'b0, 8'h14);
        add(OP_SEGMENT, 32'h0000_0000, 16'd8, 1'b0, 8'h15);
        add(OP_SEGMENT, 32'hFFFF_FFF8, 16'd16, 1'b0, 8'h16);
        add(OP_SEGMENT, 32'hFFFF_FFF0, 16'd8, 1'b0, 8'h17);
        add(OP_SEGMENT, 32'h0000_0000, 16'd10, 1'b0, 8'h18);
        add(OP_SEGMENT, 32'h0000_000E, 16'hFFFF, 1'b0, 8'hFF);
        add(OP_SEGMENT, 32'h0001_000D, 16'd0, 1'b1, 8'h19);
        add(OP_SEGMENT, 32'h0001_000E, 16'd5, 1'b1, 8'h1A);
        add(OP_SEGMENT, 32'h0000_0100, 16'd5, 1'b0, 8'h1B);
        add(OP_FIN, 32'h0, 16'h0, 1'b0, 8'h00);
        add(OP_RESET, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 8'hFF);
        add(OP_FIN, 32'h0, 16'h0, 1'b0, 8'h00);
        add(OP_SET_ISN, 32'h8000_0000, 16'h0, 1'b0, 8'h00);
        for (int k = 1; k <= 17; k++)
            add(OP_SEGMENT, 32'h8000_0000 + k * 8, 16'd8, 1'b0, 8'(k), k == 1);
        add(OP_SEGMENT, 32'h8000_0000, 16'd8, 1'b0, 8'hA0);
        add(OP_SEGMENT, 32'h0, 16'h0, 1'b0, 8'h0, 1'b1);

        // random part
        while (seg_q.size() < N_ITEMS) add_episode();
        add(OP_RESET, 32'h0, 16'h0, 1'b0, 8'h0, 1'b1);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (seg_q.size() == 0 && !push);
        wait (want_q.size() == 0);
        repeat (50) @(posedge i_clk);
        $display("%0d input transactions sent, %0d results checked", n_sent, n_checked);
        $display("%0d ranges delivered, %0d table-full drops seen", n_delivered, n_full);
        if (errors == 0 && want_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
